### sv/stq_pkg.sv
// Shared types and codes for the sorted timeout queue.
`timescale 1ns / 1ps

package stq_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NONE_DUE  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_REMOVE = 2'd2
  } cell_mode_e;

  typedef struct packed {
    op_e         operation;
    logic [15:0] conn_id;
    logic [31:0] expire_time;
    logic [31:0] now_time;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] expired_id;
    logic        last;
  } out_t;

endpackage

### sv/sorted_timeout_queue.sv
// Top level of the sorted timeout queue: chain of slots and operation sequencer.
//
//   Port group   Dir  Handshake               Payload
//   in_*         in   in_valid_i / in_stall_o  stq_pkg::in_t  (operation, id, times)
//   out_*        out  out_valid_o / out_stall_i stq_pkg::out_t (status, expired id, last)
//
// Add and delete each make at most one pass along the slot chain. Adjust makes a remove
// pass, then an insert pass. Tick latches the time, then pops one due entry from
// the chain head per cycle while the output is not stalled, one result per cycle.
// Reset empties the chain at once; no clearing pass.
// A stalled result holds the block; a new item is taken while the held result
// transfers in the same cycle.
`timescale 1ns / 1ps

module sorted_timeout_queue #(
  parameter int DEPTH     = 64,
  parameter int TIME_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  stq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output stq_pkg::out_t  out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADJ_INSERT,
    S_TICK
  } state_e;

  localparam logic [DEPTH-1:0] LSB_ONE = {{(DEPTH-1){1'b0}}, 1'b1};

  state_e                state_q;
  logic                  out_valid_q;
  logic                  out_valid_d;
  stq_pkg::out_t         out_data_q;
  logic [TIME_BITS-1:0]  hold_time_q;
  logic [15:0]           hold_id_q;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [63:0]           exp_wide;
  logic [63:0]           now_wide;
  logic [TIME_BITS-1:0]  in_exp;
  logic [TIME_BITS-1:0]  in_now;

  stq_pkg::cell_mode_e   mode;
  logic [TIME_BITS-1:0]  key_time;
  logic [15:0]           key_id;
  logic                  remove_all;

  logic [DEPTH-1:0]      valid_v;
  logic [DEPTH-1:0]      after_v;
  logic [DEPTH-1:0]      match_v;
  logic [DEPTH-1:0]      low_match;
  logic [DEPTH-1:0]      from_match;
  logic [DEPTH-1:0]      remove_sel;
  logic [TIME_BITS-1:0]  exp_v [DEPTH];
  logic [15:0]           id_v  [DEPTH];
  logic                  found;
  logic                  full;
  logic                  due0;
  logic                  due1;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || !out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  assign exp_wide = {32'd0, in_data_i.expire_time};
  assign now_wide = {32'd0, in_data_i.now_time};
  assign in_exp   = exp_wide[TIME_BITS-1:0];
  assign in_now   = now_wide[TIME_BITS-1:0];

  assign low_match  = match_v & (~match_v + LSB_ONE);
  assign from_match = ~(low_match - LSB_ONE);
  assign found      = |match_v;
  assign full       = valid_v[DEPTH-1];
  assign due0       = !after_v[0];
  assign due1       = !after_v[1];
  assign remove_sel = remove_all ? {DEPTH{1'b1}} : from_match;

  always_comb begin
    mode       = stq_pkg::MODE_HOLD;
    remove_all = 1'b0;
    out_load   = 1'b0;
    key_time   = in_exp;
    key_id     = in_data_i.conn_id;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_data_i.operation)
            stq_pkg::OP_ADD:    if (!full) mode = stq_pkg::MODE_INSERT;
            stq_pkg::OP_ADJUST,
            stq_pkg::OP_DELETE: if (found) mode = stq_pkg::MODE_REMOVE;
            default: ;
          endcase
          out_load = (in_data_i.operation != stq_pkg::OP_TICK) &&
                     ((in_data_i.operation != stq_pkg::OP_ADJUST) || !found);
        end
      end
      S_ADJ_INSERT: begin
        key_time = hold_time_q;
        key_id   = hold_id_q;
        mode     = stq_pkg::MODE_INSERT;
        out_load = 1'b1;
      end
      S_TICK: begin
        key_time   = hold_time_q;
        remove_all = 1'b1;
        out_load   = out_free;
        if (out_free && due0) mode = stq_pkg::MODE_REMOVE;
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_after;
    logic                 left_valid;
    logic [TIME_BITS-1:0] left_exp;
    logic [15:0]          left_id;
    logic                 right_valid;
    logic [TIME_BITS-1:0] right_exp;
    logic [15:0]          right_id;

    if (i == 0) begin : g_head
      assign left_after = 1'b0;
      assign left_valid = 1'b0;
      assign left_exp   = '0;
      assign left_id    = '0;
    end else begin : g_body
      assign left_after = after_v[i-1];
      assign left_valid = valid_v[i-1];
      assign left_exp   = exp_v[i-1];
      assign left_id    = id_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_exp   = '0;
      assign right_id    = '0;
    end else begin : g_mid
      assign right_valid = valid_v[i+1];
      assign right_exp   = exp_v[i+1];
      assign right_id    = id_v[i+1];
    end

    stq_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .mode_i        (mode),
      .key_time_i    (key_time),
      .key_id_i      (key_id),
      .left_after_i  (left_after),
      .remove_sel_i  (remove_sel[i]),
      .left_valid_i  (left_valid),
      .left_exp_i    (left_exp),
      .left_id_i     (left_id),
      .right_valid_i (right_valid),
      .right_exp_i   (right_exp),
      .right_id_i    (right_id),
      .valid_o       (valid_v[i]),
      .exp_o         (exp_v[i]),
      .id_o          (id_v[i]),
      .after_o       (after_v[i]),
      .match_o       (match_v[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      hold_time_q  <= '0;
      hold_id_q    <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_data_q.expired_id <= '0;
            out_data_q.last       <= 1'b1;
            case (in_data_i.operation)
              stq_pkg::OP_ADD: begin
                out_data_q.status <= full ? stq_pkg::ST_FULL : stq_pkg::ST_OK;
              end
              stq_pkg::OP_ADJUST: begin
                hold_time_q <= in_exp;
                hold_id_q   <= in_data_i.conn_id;
                if (found) begin
                  state_q <= S_ADJ_INSERT;
                end else begin
                  out_data_q.status <= stq_pkg::ST_NOT_FOUND;
                end
              end
              stq_pkg::OP_DELETE: begin
                out_data_q.status <= found ? stq_pkg::ST_OK : stq_pkg::ST_NOT_FOUND;
              end
              default: begin
                hold_time_q <= in_now;
                state_q     <= S_TICK;
              end
            endcase
          end
        end
        S_ADJ_INSERT: begin
          out_data_q.status     <= stq_pkg::ST_OK;
          out_data_q.expired_id <= '0;
          out_data_q.last       <= 1'b1;
          state_q               <= S_IDLE;
        end
        S_TICK: begin
          if (out_free) begin
            if (due0) begin
              out_data_q.status     <= stq_pkg::ST_EXPIRED;
              out_data_q.expired_id <= id_v[0];
              out_data_q.last       <= !due1;
              if (!due1) state_q <= S_IDLE;
            end else begin
              out_data_q.status     <= stq_pkg::ST_NONE_DUE;
              out_data_q.expired_id <= '0;
              out_data_q.last       <= 1'b1;
              state_q               <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/stq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`timescale 1ns / 1ps

module stq_cell #(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stq_pkg::cell_mode_e    mode_i,
  input  logic [TIME_BITS-1:0]   key_time_i,
  input  logic [15:0]            key_id_i,
  input  logic                   left_after_i,
  input  logic                   remove_sel_i,
  input  logic                   left_valid_i,
  input  logic [TIME_BITS-1:0]   left_exp_i,
  input  logic [15:0]            left_id_i,
  input  logic                   right_valid_i,
  input  logic [TIME_BITS-1:0]   right_exp_i,
  input  logic [15:0]            right_id_i,
  output logic                   valid_o,
  output logic [TIME_BITS-1:0]   exp_o,
  output logic [15:0]            id_o,
  output logic                   after_o,
  output logic                   match_o
);

  logic                 valid_q, valid_d;
  logic [TIME_BITS-1:0] exp_q, exp_d;
  logic [15:0]          id_q, id_d;

  assign after_o = !valid_q || (exp_q > key_time_i);
  assign match_o = valid_q && (id_q == key_id_i);
  assign valid_o = valid_q;
  assign exp_o   = exp_q;
  assign id_o    = id_q;

  always_comb begin
    valid_d = valid_q;
    exp_d   = exp_q;
    id_d    = id_q;
    case (mode_i)
      stq_pkg::MODE_INSERT: begin
        if (after_o) begin
          if (left_after_i) begin
            valid_d = left_valid_i;
            exp_d   = left_exp_i;
            id_d    = left_id_i;
          end else begin
            valid_d = 1'b1;
            exp_d   = key_time_i;
            id_d    = key_id_i;
          end
        end
      end
      stq_pkg::MODE_REMOVE: begin
        if (remove_sel_i) begin
          valid_d = right_valid_i;
          exp_d   = right_exp_i;
          id_d    = right_id_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
    id_q  <= id_d;
  end

endmodule
